// File: sv/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared constants and digit helpers for the packed-BCD arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package bcd_pkg;
  localparam int DIGITS   = 16;
  localparam int DIG_W    = 4;
  localparam int WORD_W   = 64;
  localparam int USED_W   = DIGITS * DIG_W;
  localparam int CNT_W    = $clog2(DIGITS + 1);

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_MOD = 3'd3;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_OVF  = 3'd1;
  localparam logic [2:0] ST_NEG  = 3'd2;
  localparam logic [2:0] ST_DIV0 = 3'd3;
  localparam logic [2:0] ST_BAD  = 3'd4;

  typedef logic [USED_W-1:0] bcd_t;

  // One decimal digit add with carry in; returns {carry, digit}.
  function automatic logic [4:0] dig_add(input logic [3:0] x, input logic [3:0] y,
                                         input logic c);
    logic [4:0] s;
    s = {1'b0, x} + {1'b0, y} + {4'd0, c};
    if (s > 5'd9) dig_add = {1'b1, 4'(s - 5'd10)};
    else dig_add = {1'b0, s[3:0]};
  endfunction

  // One decimal digit subtract with borrow in; returns {borrow, digit}.
  function automatic logic [4:0] dig_sub(input logic [3:0] x, input logic [3:0] y,
                                         input logic b);
    logic [5:0] s;
    s = {2'b0, x} - {2'b0, y} - {5'd0, b};
    if (s[5]) dig_sub = {1'b1, 4'(s + 6'd10)};
    else dig_sub = {1'b0, s[3:0]};
  endfunction
endpackage
`default_nettype wire

// File: sv/bcd_decimal_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// bcd_decimal_arithmetic_unit_top
// Packed-BCD add, subtract, multiply, modulo and compare, digit serial.
// ----------------------------------------------------------------------------
// One request on in_valid/in_ready carries kind, a_digits and b_digits; one
// response on out_valid/out_ready carries the result, status and flags.
// Work runs one digit per cycle through a shared digit adder/subtractor.
// Digit checking and compare of both words come first, then the word adds
// on the digit adder/subtractor. Add/subtract make a single word add or
// subtract; multiply does up to nine word adds per digit of a, modulo up to
// ten word subtracts per digit of a. One request is in work at a time; the
// next is taken once the result is registered, even while the receiver
// stalls it, which holds the result stable. A finished result that finds
// the output register full waits in the sequencer, and no request is taken
// until it moves over. Synchronous reset empties the output register and
// returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none
module bcd_decimal_arithmetic_unit_top
  import bcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        kind,
  input  wire logic [WORD_W-1:0] a_digits,
  input  wire logic [WORD_W-1:0] b_digits,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      result_digits,
  output logic [2:0]             status,
  output logic                   a_less,
  output logic                   a_equal,
  output logic                   a_greater,
  output logic                   result_zero
);
  logic       busy, go, fin, pend, load;
  bcd_t       res;
  logic [2:0] st;
  logic [1:0] cmp;

  assign in_ready = !busy;
  assign go       = in_valid && in_ready;
  assign load     = (fin || pend) && (!out_valid || out_ready);

  bcd_seq u_seq (
    .clk(clk), .rst(rst), .go(go), .kind(kind),
    .a(a_digits[USED_W-1:0]), .b(b_digits[USED_W-1:0]),
    .fin(fin), .res(res), .st(st), .cmp(cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (go) busy <= 1'b1;
      else if (load) busy <= 1'b0;
      if (load) pend <= 1'b0;
      else if (fin) pend <= 1'b1;
      if (load) begin
        result_digits <= WORD_W'(res);
        status        <= st;
        a_less        <= cmp[1];
        a_equal       <= cmp[0];
        a_greater     <= (cmp == 2'b00);
        result_zero   <= (res == '0);
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/bcd_digit_alu.sv
// ----------------------------------------------------------------------------
// bcd_digit_alu
// Digit-serial add or subtract of two BCD words, least significant digit first.
// ----------------------------------------------------------------------------
`default_nettype none
module bcd_digit_alu
  import bcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       sub,
  input  wire bcd_t       x,
  input  wire bcd_t       y,
  output logic            done,
  output bcd_t            sum,
  output logic            carry
);
  bcd_t            xs, ys;
  logic [CNT_W-1:0] cnt;
  logic            busy, sub_r;
  logic [4:0]      d;

  always_comb begin
    if (sub_r) d = dig_sub(xs[3:0], ys[3:0], carry);
    else d = dig_add(xs[3:0], ys[3:0], carry);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      xs    <= x;
      ys    <= y;
      sub_r <= sub;
      carry <= 1'b0;
      cnt   <= '0;
    end else if (busy) begin
      xs    <= xs >> DIG_W;
      ys    <= ys >> DIG_W;
      sum   <= {d[3:0], sum[USED_W-1:DIG_W]};
      carry <= d[4];
      cnt   <= cnt + 1'b1;
      if (cnt == CNT_W'(DIGITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/bcd_seq.sv
// ----------------------------------------------------------------------------
// bcd_seq
// Sequencer: validation, compare, add/subtract, and multiply/modulo by repeated digit ops.
// ----------------------------------------------------------------------------
`default_nettype none
module bcd_seq
  import bcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire logic [2:0] kind,
  input  wire bcd_t       a,
  input  wire bcd_t       b,
  output logic            fin,
  output bcd_t            res,
  output logic [2:0]      st,
  output logic [1:0]      cmp
);
  typedef enum logic [3:0] {S_IDLE, S_CHK, S_ADD, S_SUB, S_MSHIFT, S_MADD, S_MSTEP,
                            S_DSHIFT, S_DSUB, S_DONE} state_t;
  state_t           state;
  logic [2:0]       k;
  bcd_t             ra, rb, acc, ma, rem;
  logic [3:0]       rem_top;
  logic [CNT_W-1:0] idx;
  logic [3:0]       dig, rep;
  logic             bad, alu_start, alu_sub, alu_done, alu_c;
  bcd_t             alu_x, alu_y, alu_s;
  logic             nz_b;

  bcd_digit_alu u_alu (
    .clk(clk), .rst(rst), .start(alu_start), .sub(alu_sub),
    .x(alu_x), .y(alu_y), .done(alu_done), .sum(alu_s), .carry(alu_c)
  );

  always_ff @(posedge clk) begin
    fin       <= 1'b0;
    alu_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      fin   <= 1'b0;
      alu_start <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go) begin
            ra <= a; rb <= b; k <= kind;
            idx <= '0; bad <= 1'b0; cmp <= 2'b01; nz_b <= 1'b0;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          // scan from most significant digit, one per cycle
          if (ra[USED_W-1 -: 4] > 4'd9 || rb[USED_W-1 -: 4] > 4'd9) bad <= 1'b1;
          if (rb[USED_W-1 -: 4] != 4'd0) nz_b <= 1'b1;
          if (cmp == 2'b01 && ra[USED_W-1 -: 4] != rb[USED_W-1 -: 4])
            cmp <= (ra[USED_W-1 -: 4] < rb[USED_W-1 -: 4]) ? 2'b10 : 2'b00;
          ra  <= {ra[USED_W-DIG_W-1:0], ra[USED_W-1 -: 4]};
          rb  <= {rb[USED_W-DIG_W-1:0], rb[USED_W-1 -: 4]};
          idx <= idx + 1'b1;
          if (idx == CNT_W'(DIGITS - 1)) state <= S_ADD;
        end
        S_ADD: begin
          res <= '0; st <= ST_OK; idx <= '0;
          if (bad) begin
            st <= ST_BAD; state <= S_DONE;
          end else begin
            case (k)
              KIND_ADD, KIND_SUB: begin
                alu_x <= ra; alu_y <= rb; alu_sub <= (k == KIND_SUB);
                alu_start <= 1'b1; state <= S_SUB;
              end
              KIND_MUL: begin
                acc <= '0; ma <= ra; state <= S_MSHIFT;
              end
              KIND_MOD: begin
                if (!nz_b) begin
                  st <= ST_DIV0; state <= S_DONE;
                end else begin
                  rem <= '0; rem_top <= '0; ma <= ra; state <= S_DSHIFT;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SUB: begin
          if (alu_done) begin
            if (alu_c) st <= (k == KIND_SUB) ? ST_NEG : ST_OVF;
            else res <= alu_s;
            state <= S_DONE;
          end
        end
        // multiply: acc = acc*10 + a_digit*b, most significant digit of a first
        S_MSHIFT: begin
          if (acc[USED_W-1 -: 4] != 4'd0) begin
            st <= ST_OVF; state <= S_DONE;
          end else begin
            acc <= acc << DIG_W;
            dig <= ma[USED_W-1 -: 4];
            ma  <= ma << DIG_W;
            rep <= '0;
            state <= S_MADD;
          end
        end
        S_MADD: begin
          if (rep == dig) begin
            idx <= idx + 1'b1;
            state <= (idx == CNT_W'(DIGITS - 1)) ? S_MSTEP : S_MSHIFT;
            if (idx == CNT_W'(DIGITS - 1)) res <= acc;
          end else if (!alu_start) begin
            alu_x <= acc; alu_y <= rb; alu_sub <= 1'b0; alu_start <= 1'b1;
            state <= S_DSUB;
          end
        end
        S_MSTEP: state <= S_DONE;
        // modulo: rem = rem*10 + a_digit, then subtract b while possible;
        // rem_top holds the digit shifted out above the word
        S_DSHIFT: begin
          rem_top <= rem[USED_W-1 -: 4];
          rem <= {rem[USED_W-DIG_W-1:0], ma[USED_W-1 -: 4]};
          ma  <= ma << DIG_W;
          alu_x <= {rem[USED_W-DIG_W-1:0], ma[USED_W-1 -: 4]};
          alu_y <= rb; alu_sub <= 1'b1; alu_start <= 1'b1;
          state <= S_DSUB;
        end
        S_DSUB: begin
          if (alu_done) begin
            if (k == KIND_MUL) begin
              if (alu_c) begin
                st <= ST_OVF; state <= S_DONE;
              end else begin
                acc <= alu_s; rep <= rep + 1'b1; state <= S_MADD;
              end
            end else if (!alu_c || rem_top != 4'd0) begin
              rem <= alu_s; rem_top <= rem_top - {3'd0, alu_c};
              alu_x <= alu_s; alu_start <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
              if (idx == CNT_W'(DIGITS - 1)) begin
                res <= rem; state <= S_DONE;
              end else state <= S_DSHIFT;
            end
          end
        end
        S_DONE: begin
          fin <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
